### rtl/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg: shared constants and types for the cache tag store
// geometry, field widths, set row layout and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

  // floor of log2, evaluated at elaboration
  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int NumSets    = 64;
  localparam int NumWays    = 4;
  localparam int BlockBytes = 32;

  localparam int AddrW   = 32;
  localparam int OfsW    = flog2(BlockBytes);
  localparam int SetW    = flog2(NumSets);
  localparam int TagW    = AddrW - OfsW - SetW;
  localparam int WayW    = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int WayOutW = 2;
  localparam int LatW    = 8;
  localparam int RrpvW   = 2;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgPolicy  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPenalty = 1'd1;

  localparam logic [LatW-1:0]  ResetPenalty = 8'd50;
  localparam logic [RrpvW-1:0] RrpvHit      = 2'd0;
  localparam logic [RrpvW-1:0] RrpvInsert   = 2'd2;
  localparam logic [RrpvW-1:0] RrpvDistant  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [TagW-1:0]   tag;
    logic [WayW-1:0]   rank;
    logic [RrpvW-1:0]  rrpv;
  } way_t;

  typedef way_t [NumWays-1:0] row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

`default_nettype wire

### rtl/set_assoc_cache_tags_replacement.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tags_replacement: set-associative tag store with lru/srrip
// one synchronous row per set holds every way; lookup does read-modify-write
// ----------------------------------------------------------------------------
//
//  channel   signals                                    handshake
//  -------   -----------------------------------------  ----------------------
//  access    address_i                                  start & !busy
//  result    hit_o way_used_o latency_o misaligned_o    valid_o, one cycle
//  config    cfg_idx_i cfg_wdata_i                      cfg_we_i
//
//  aligned access: set row read, then compare and write back;
//  busy is high during compare and write back and the result shows in the cycle after.
//  misaligned access: no row access, busy stays low.
//  rows never written since reset read as reset contents (per-set flag);
//  there is no clearing pass. the result cannot be stalled.
`default_nettype none

module set_assoc_cache_tags_replacement
  import sact_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire [AddrW-1:0]     address_i,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i,
  output logic                valid_o,
  output logic                hit_o,
  output logic [WayOutW-1:0]  way_used_o,
  output logic [LatW-1:0]     latency_o,
  output logic                misaligned_o
);

  state_e state_q, state_d;

  logic             policy_q;
  logic [LatW-1:0]  penalty_q;

  logic [AddrW-1:0] addr_q;
  logic             accept;
  logic             rd_en;
  logic             wr_en;

  row_t             mem [NumSets];
  row_t             rd_row_q;
  logic             rd_init_q;
  logic [NumSets-1:0] init_q;
  row_t             wr_row;

  logic [SetW-1:0]  rd_set;
  logic [SetW-1:0]  cur_set;
  logic [TagW-1:0]  cur_tag;

  logic               valid_d, hit_d, mis_d;
  logic [WayOutW-1:0] way_d;
  logic [LatW-1:0]    lat_d;
  logic               valid_q, hit_q, mis_q;
  logic [WayOutW-1:0] way_q;
  logic [LatW-1:0]    lat_q;

  // lookup datapath
  row_t             row_cur;
  row_t             row_new;
  logic [NumWays-1:0] hit_vec;
  logic             lk_hit;
  logic             any_inv;
  logic [WayW-1:0]  hit_way;
  logic [WayW-1:0]  inv_way;
  logic [WayW-1:0]  lru_way;
  logic [WayW-1:0]  rrip_way;
  logic [WayW-1:0]  use_way;
  logic [RrpvW-1:0] max_rrpv;
  logic [RrpvW-1:0] age;
  logic [WayW-1:0]  old_rank;
  logic             do_age;

  assign accept  = start && !busy;
  assign rd_set  = address_i[OfsW +: SetW];
  assign cur_set = addr_q[OfsW +: SetW];
  assign cur_tag = addr_q[AddrW-1 -: TagW];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= 1'b0;
      penalty_q <= ResetPenalty;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPolicy:  policy_q  <= cfg_wdata_i[0];
        CfgPenalty: penalty_q <= cfg_wdata_i[LatW-1:0];
        default: ;
      endcase
    end
  end

  // set row memory
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= mem[rd_set];
    end
    if (wr_en) begin
      mem[cur_set] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_init_q <= init_q[rd_set];
      end
      if (wr_en) begin
        init_q[cur_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= address_i;
    end
  end

  // row contents, with untouched sets showing reset state
  always_comb begin
    for (int w = 0; w < NumWays; w++) begin
      if (rd_init_q) begin
        row_cur[w] = rd_row_q[w];
      end else begin
        row_cur[w].valid = 1'b0;
        row_cur[w].tag   = '0;
        row_cur[w].rank  = WayW'(w);
        row_cur[w].rrpv  = RrpvInsert;
      end
    end
  end

  always_comb begin
    hit_vec  = '0;
    hit_way  = '0;
    inv_way  = '0;
    lru_way  = '0;
    rrip_way = '0;
    any_inv  = 1'b0;
    max_rrpv = '0;
    for (int w = 0; w < NumWays; w++) begin
      hit_vec[w] = row_cur[w].valid && (row_cur[w].tag == cur_tag);
      if (!row_cur[w].valid) begin
        any_inv = 1'b1;
      end
      if (row_cur[w].rrpv > max_rrpv) begin
        max_rrpv = row_cur[w].rrpv;
      end
    end
    lk_hit = |hit_vec;
    age    = RrpvDistant - max_rrpv;

    // lowest way wins: scan downwards
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WayW'(w);
      end
      if (!row_cur[w].valid) begin
        inv_way = WayW'(w);
      end
      if (row_cur[w].rank == WayW'(NumWays - 1)) begin
        lru_way = WayW'(w);
      end
      if (row_cur[w].rrpv + age == RrpvDistant) begin
        rrip_way = WayW'(w);
      end
    end

    do_age = !lk_hit && !any_inv && policy_q;
    if (lk_hit) begin
      use_way = hit_way;
    end else if (any_inv) begin
      use_way = inv_way;
    end else if (policy_q) begin
      use_way = rrip_way;
    end else begin
      use_way = lru_way;
    end
    old_rank = row_cur[use_way].rank;

    row_new = row_cur;
    for (int w = 0; w < NumWays; w++) begin
      if (do_age && row_cur[w].valid) begin
        row_new[w].rrpv = row_cur[w].rrpv + age;
      end
      if (WayW'(w) == use_way) begin
        row_new[w].rank = '0;
        if (lk_hit) begin
          row_new[w].rrpv = RrpvHit;
        end else begin
          row_new[w].valid = 1'b1;
          row_new[w].tag   = cur_tag;
          row_new[w].rrpv  = RrpvInsert;
        end
      end else if (row_cur[w].valid && row_cur[w].rank < old_rank) begin
        row_new[w].rank = row_cur[w].rank + 1'b1;
      end
    end
  end

  assign wr_row = row_new;

  // controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    way_q <= way_d;
    lat_q <= lat_d;
    mis_q <= mis_d;
  end

  always_comb begin
    state_d = state_q;
    busy    = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    valid_d = 1'b0;
    hit_d   = 1'b0;
    way_d   = '0;
    lat_d   = '0;
    mis_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (address_i[1:0] != 2'b00) begin
            valid_d = 1'b1;
            mis_d   = 1'b1;
          end else begin
            rd_en   = 1'b1;
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        busy    = 1'b1;
        wr_en   = 1'b1;
        valid_d = 1'b1;
        hit_d   = lk_hit;
        way_d   = WayOutW'(use_way);
        lat_d   = lk_hit ? '0 : penalty_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign valid_o      = valid_q;
  assign hit_o        = hit_q;
  assign way_used_o   = way_q;
  assign latency_o    = lat_q;
  assign misaligned_o = mis_q;

endmodule

`default_nettype wire

### rtl/sact_checker.sv
// ----------------------------------------------------------------------------
// sact_checker: port-level checks for the cache tag store
// timing of results against accepted words and result field consistency
// ----------------------------------------------------------------------------
`default_nettype none

module sact_checker
  import sact_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                start,
  input wire                busy,
  input wire [AddrW-1:0]    address_i,
  input wire                valid_o,
  input wire                hit_o,
  input wire [WayOutW-1:0]  way_used_o,
  input wire [LatW-1:0]     latency_o,
  input wire                misaligned_o
);

  // misaligned word answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && address_i[1:0] != 2'b00) |=> (valid_o && misaligned_o))
    else $error("misaligned word not answered in the next cycle");

  // aligned word: busy while the lookup runs, then a lookup result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && address_i[1:0] == 2'b00) |=>
      (busy && !valid_o) ##1 (valid_o && !misaligned_o && !busy))
    else $error("aligned word result timing wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (latency_o == '0 && !misaligned_o))
    else $error("hit with nonzero latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && misaligned_o) |-> (!hit_o && way_used_o == '0 && latency_o == '0))
    else $error("misaligned result carries lookup fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

endmodule

bind set_assoc_cache_tags_replacement sact_checker u_sact_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .address_i    (address_i),
  .valid_o      (valid_o),
  .hit_o        (hit_o),
  .way_used_o   (way_used_o),
  .latency_o    (latency_o),
  .misaligned_o (misaligned_o)
);

`default_nettype wire
